// ===== hw/rtl/delta_block_raw_decoder_top_defines.svh =====
// Assertion macros for the delta block raw decoder checkers.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef DELTA_BLOCK_RAW_DECODER_TOP_DEFINES_SVH
`define DELTA_BLOCK_RAW_DECODER_TOP_DEFINES_SVH

// Plain property, sampled on the rising clock edge, off while in reset.
`define DBRD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dbrd check failed in %m");

// Same-cycle implication.
`define DBRD_ASSERT_IMP(lbl, ante, cons) `DBRD_ASSERT(lbl, (ante) |-> (cons))

// Next-cycle implication.
`define DBRD_ASSERT_NXT(lbl, ante, cons) `DBRD_ASSERT(lbl, (ante) |=> (cons))

`endif

// ===== hw/rtl/dbrd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbrd_pkg
// Shared constants, register map and types of the delta block raw decoder.
// ----------------------------------------------------------------------------
package dbrd_pkg;

  localparam int unsigned MaxWidth    = 8192;
  localparam int unsigned MaxRows     = 8192;
  localparam int unsigned BlockPixels = 16;
  localparam int unsigned GroupCols   = 32;
  localparam int unsigned MaxGroups   = MaxWidth / GroupCols;

  // Field widths
  localparam int unsigned WordW   = 64;
  localparam int unsigned BlockW  = 2 * WordW;
  localparam int unsigned SampW   = 11;
  localparam int unsigned RawW    = 12;
  localparam int unsigned PixW    = 15;
  localparam int unsigned ColW    = 13;
  localparam int unsigned RowW    = 13;
  localparam int unsigned IdxW    = $clog2(BlockPixels);
  localparam int unsigned ShW     = 3;
  localparam int unsigned GrpCfgW = 9;
  localparam int unsigned RowCfgW = 14;
  localparam int unsigned BirW    = $clog2(2 * MaxGroups);
  localparam int unsigned CntRowW = $clog2(MaxRows);

  // Header layout and delta stream
  localparam int unsigned MaxLsb    = 0;
  localparam int unsigned MinLsb    = 11;
  localparam int unsigned IMaxLsb   = 22;
  localparam int unsigned IMinLsb   = 26;
  localparam int unsigned DeltaBase = 30;
  localparam int unsigned DeltaW    = 7;
  localparam int unsigned DeltaBits = BlockW - DeltaBase;
  localparam int unsigned DeltaIdxW = $clog2(DeltaBits + 1);
  localparam int unsigned RangeW    = 16;
  localparam int unsigned DeltaSpan = 128;
  localparam int unsigned MaxShift  = 4;

  // Linearization curve
  localparam int unsigned CurveKnee   = 2000;
  localparam int unsigned CurveOffset = 12000;

  // Configuration port
  localparam int unsigned NumRegs = 3;
  localparam int unsigned DataW   = 32;
  localparam int unsigned PaddrW  = $clog2(4 * NumRegs);
  localparam int unsigned RegIdxW = PaddrW - 2;

  localparam logic [RegIdxW-1:0] RegGroupsPerRow = RegIdxW'(0);
  localparam logic [RegIdxW-1:0] RegRowsPerImage = RegIdxW'(1);
  localparam logic [RegIdxW-1:0] RegApplyCurve   = RegIdxW'(2);

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef struct packed {
    logic [GrpCfgW-1:0] groups_per_row;
    logic [RowCfgW-1:0] rows_per_image;
    logic               apply_curve;
  } cfg_t;

  // One classified block, handed from the front end to the back end
  typedef struct packed {
    logic [DeltaBits-1:0] deltas;
    logic [SampW-1:0]     mx;
    logic [SampW-1:0]     mn;
    logic [IdxW-1:0]      imax;
    logic [IdxW-1:0]      imin;
    logic [ShW-1:0]       sh;
    logic [ColW-1:0]      base_col;
    logic [RowW-1:0]      row;
    logic                 img_end;
  } desc_t;

endpackage

// ===== hw/rtl/dbrd_if.sv =====
// ----------------------------------------------------------------------------
// dbrd_if
// Valid/ready channels: compressed blocks in, decoded pixels out.
// ----------------------------------------------------------------------------
interface dbrd_blk_if;
  import dbrd_pkg::*;

  logic             valid;
  logic             ready;
  logic [WordW-1:0] block_low;
  logic [WordW-1:0] block_high;

  modport source (output valid, output block_low, output block_high, input ready);
  modport sink (input valid, input block_low, input block_high, output ready);
endinterface

interface dbrd_pix_if;
  import dbrd_pkg::*;

  logic            valid;
  logic            ready;
  logic [PixW-1:0] pixel_value;
  logic [ColW-1:0] column;
  logic [RowW-1:0] row;
  logic            last_of_block;
  logic            last_of_image;

  modport source (
    output valid, output pixel_value, output column, output row,
    output last_of_block, output last_of_image, input ready
  );
  modport sink (
    input valid, input pixel_value, input column, input row,
    input last_of_block, input last_of_image, output ready
  );
endinterface

// ===== hw/rtl/dbrd_front.sv =====
// ----------------------------------------------------------------------------
// dbrd_front
// Accepts a block, splits the header, picks the shift and tags the block
// with its column base, row and end-of-image flag.
// ----------------------------------------------------------------------------
module dbrd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dbrd_pkg::cfg_t cfg_i,
  dbrd_blk_if.sink       in_i,
  input  logic           full_i,
  output logic           push_o,
  output dbrd_pkg::desc_t desc_o
);
  import dbrd_pkg::*;

  logic [BirW-1:0]    bir_q, bir_d;
  logic [CntRowW-1:0] row_q, row_d;

  logic [SampW-1:0]  mx, mn;
  logic [RangeW-1:0] range;
  logic [ShW-1:0]    sh;
  logic [BirW-1:0]   eff_groups;
  logic [BirW-1:0]   last_block;
  logic [CntRowW-1:0] last_row;
  logic              row_end, img_end;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  assign mx    = in_i.block_low[MaxLsb +: SampW];
  assign mn    = in_i.block_low[MinLsb +: SampW];
  assign range = RangeW'(mx) - RangeW'(mn);

  // Least shift whose span covers the range; a wrapped range lands on the top
  always_comb begin
    sh = ShW'(MaxShift);
    for (int n = MaxShift - 1; n >= 0; n--) begin
      if (range < RangeW'(DeltaSpan << n)) sh = ShW'(n);
    end
  end

  always_comb begin
    if (cfg_i.groups_per_row == '0) begin
      eff_groups = BirW'(1);
    end else if (32'(cfg_i.groups_per_row) > MaxGroups) begin
      eff_groups = BirW'(MaxGroups);
    end else begin
      eff_groups = BirW'(cfg_i.groups_per_row);
    end
    last_block = BirW'(({1'b0, eff_groups} << 1) - 1'b1);

    if (cfg_i.rows_per_image == '0) begin
      last_row = '0;
    end else if (32'(cfg_i.rows_per_image) > MaxRows) begin
      last_row = CntRowW'(MaxRows - 1);
    end else begin
      last_row = CntRowW'(cfg_i.rows_per_image - 1'b1);
    end
  end

  assign row_end = bir_q >= last_block;
  assign img_end = row_end && (row_q >= last_row);

  always_comb begin
    desc_o.deltas   = {in_i.block_high, in_i.block_low[WordW-1:DeltaBase]};
    desc_o.mx       = mx;
    desc_o.mn       = mn;
    desc_o.imax     = in_i.block_low[IMaxLsb +: IdxW];
    desc_o.imin     = in_i.block_low[IMinLsb +: IdxW];
    desc_o.sh       = sh;
    // Even block of a pair takes even columns, odd block the odd ones
    desc_o.base_col = ColW'({bir_q[BirW-1:1], 4'b0000, bir_q[0]});
    desc_o.row      = RowW'(row_q);
    desc_o.img_end  = img_end;
  end

  always_comb begin
    bir_d = bir_q;
    row_d = row_q;
    if (push_o) begin
      if (row_end) begin
        bir_d = '0;
        row_d = img_end ? '0 : row_q + 1'b1;
      end else begin
        bir_d = bir_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bir_q <= '0;
      row_q <= '0;
    end else begin
      bir_q <= bir_d;
      row_q <= row_d;
    end
  end

endmodule

// ===== hw/rtl/dbrd_queue.sv =====
// ----------------------------------------------------------------------------
// dbrd_queue
// Two-entry descriptor queue between the front end and the back end.
// ----------------------------------------------------------------------------
module dbrd_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  dbrd_pkg::desc_t desc_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output dbrd_pkg::desc_t desc_o
);
  import dbrd_pkg::*;

  desc_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0]  cnt_q, cnt_d;

  assign full_o  = cnt_q == QCntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign desc_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !(pop_i && valid_o)) cnt_d = cnt_q + 1'b1;
    if (!push_i && pop_i && valid_o)   cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= desc_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i && valid_o) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
      end
    end
  end

endmodule

// ===== hw/rtl/dbrd_back.sv =====
// ----------------------------------------------------------------------------
// dbrd_back
// Steps through the sixteen pixels of the current block, one per cycle while
// the output does not stall, and drives the registered pixel channel.
// ----------------------------------------------------------------------------
module dbrd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            apply_curve_i,
  input  logic            q_valid_i,
  input  dbrd_pkg::desc_t q_desc_i,
  output logic            pop_o,
  dbrd_pix_if.source      out_o
);
  import dbrd_pkg::*;

  logic                active_q;
  desc_t               cur_q;
  logic [IdxW-1:0]     emit_q;
  logic [IdxW-1:0]     dcnt_q;
  logic                out_valid_q;
  logic [PixW-1:0]     pix_q;
  logic [ColW-1:0]     col_q;
  logic [RowW-1:0]     row_q;
  logic                lob_q, loi_q;

  logic                adv, last_pix, special;
  logic [DeltaIdxW-1:0] dpos;
  logic [DeltaBits+DeltaW-1:0] dsrc;
  logic [DeltaW-1:0]   delta;
  logic [RawW-1:0]     raw;
  logic [PixW-1:0]     pix;

  assign adv      = active_q && (!out_valid_q || out_o.ready);
  assign last_pix = emit_q == IdxW'(BlockPixels - 1);
  assign pop_o    = q_valid_i && (!active_q || (adv && last_pix));
  assign special  = (emit_q == cur_q.imax) || (emit_q == cur_q.imin);

  // Delta bits past the end of the block read as zero
  assign dsrc  = {{DeltaW{1'b0}}, cur_q.deltas};
  assign dpos  = DeltaIdxW'(({3'b000, dcnt_q} << 3) - {3'b000, dcnt_q});
  assign delta = dsrc[dpos +: DeltaW];

  always_comb begin
    if (emit_q == cur_q.imax) begin
      raw = RawW'(cur_q.mx);
    end else if (emit_q == cur_q.imin) begin
      raw = RawW'(cur_q.mn);
    end else begin
      raw = RawW'(delta) << cur_q.sh;
      raw = raw + RawW'(cur_q.mn);
    end
  end

  always_comb begin
    if (!apply_curve_i) begin
      pix = PixW'(raw);
    end else if (raw < RawW'(CurveKnee)) begin
      pix = PixW'({raw, 1'b0});
    end else begin
      pix = PixW'({raw, 3'b000}) - PixW'(CurveOffset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      emit_q      <= '0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        active_q <= 1'b1;
        emit_q   <= '0;
        dcnt_q   <= '0;
      end else if (adv && last_pix) begin
        active_q <= 1'b0;
      end else if (adv) begin
        emit_q <= emit_q + 1'b1;
        if (!special) dcnt_q <= dcnt_q + 1'b1;
      end

      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= q_desc_i;
    if (adv) begin
      pix_q <= pix;
      col_q <= cur_q.base_col + ColW'({emit_q, 1'b0});
      row_q <= cur_q.row;
      lob_q <= last_pix;
      loi_q <= last_pix && cur_q.img_end;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.pixel_value   = pix_q;
  assign out_o.column        = col_q;
  assign out_o.row           = row_q;
  assign out_o.last_of_block = lob_q;
  assign out_o.last_of_image = loi_q;

endmodule

// ===== hw/rtl/delta_block_raw_decoder_top.sv =====
// ----------------------------------------------------------------------------
// delta_block_raw_decoder_top
// Decodes 16-byte delta-coded raw blocks into sixteen tagged pixels each.
// ----------------------------------------------------------------------------
//  channel  dir  width  carries
//  in_i     in   128    block_low, block_high: one compressed block
//  out_o    out  43     pixel_value, column, row, last_of_block, last_of_image
//  apb      in   4/32   groups_per_row, rows_per_image, apply_curve
//
//  The back end emits one pixel per cycle, while the output is not stalled,
//  from its sixteen-step emit counter, through a registered pixel output.
//  A two-entry queue lets the input take blocks while the output stalls.
//  Reset clears counters and queue and loads the register reset values.
// ----------------------------------------------------------------------------
module delta_block_raw_decoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  dbrd_blk_if.sink                   in_i,
  dbrd_pix_if.source                 out_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dbrd_pkg::PaddrW-1:0] paddr,
  input  logic [dbrd_pkg::DataW-1:0]  pwdata,
  output logic [dbrd_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import dbrd_pkg::*;

  cfg_t             cfg_q;
  logic [RegIdxW-1:0] reg_idx;
  logic             wr_en;

  logic  push, full, pop, q_valid;
  desc_t f_desc, q_desc;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PaddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.groups_per_row <= GrpCfgW'(123);
      cfg_q.rows_per_image <= RowCfgW'(1);
      cfg_q.apply_curve    <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_idx)
        RegGroupsPerRow: cfg_q.groups_per_row <= pwdata[GrpCfgW-1:0];
        RegRowsPerImage: cfg_q.rows_per_image <= pwdata[RowCfgW-1:0];
        RegApplyCurve:   cfg_q.apply_curve    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegGroupsPerRow: prdata = DataW'(cfg_q.groups_per_row);
      RegRowsPerImage: prdata = DataW'(cfg_q.rows_per_image);
      RegApplyCurve:   prdata = DataW'(cfg_q.apply_curve);
      default:         prdata = '0;
    endcase
  end

  dbrd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .desc_o (f_desc)
  );

  dbrd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (f_desc),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .desc_o  (q_desc)
  );

  dbrd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .apply_curve_i (cfg_q.apply_curve),
    .q_valid_i     (q_valid),
    .q_desc_i      (q_desc),
    .pop_o         (pop),
    .out_o         (out_o)
  );

endmodule

// ===== hw/rtl/dbrd_checker.sv =====
// ----------------------------------------------------------------------------
// dbrd_checker
// Port-level checks on the pixel channel of the decoder.
// ----------------------------------------------------------------------------
`include "delta_block_raw_decoder_top_defines.svh"

module dbrd_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [dbrd_pkg::PixW-1:0] pixel_value,
  input logic [dbrd_pkg::ColW-1:0] column,
  input logic                      last_of_block,
  input logic                      last_of_image
);
  import dbrd_pkg::*;

  // End of image only on the closing pixel of a block
  `DBRD_ASSERT_IMP(a_img_on_block, out_valid && last_of_image, last_of_block)

  // The closing pixel sits in the top column pair of its group
  `DBRD_ASSERT_IMP(a_last_col, out_valid, last_of_block == (column[4:1] == 4'hF))

  // Pixels of one block leave without gaps once the sink takes them
  `DBRD_ASSERT_NXT(a_no_gap, out_valid && out_ready && !last_of_block, out_valid)

  // A stalled pixel holds
  `DBRD_ASSERT_NXT(a_hold, out_valid && !out_ready, out_valid && $stable(pixel_value))

endmodule

bind delta_block_raw_decoder_top dbrd_checker u_dbrd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid     (out_o.valid),
  .out_ready     (out_o.ready),
  .pixel_value   (out_o.pixel_value),
  .column        (out_o.column),
  .last_of_block (out_o.last_of_block),
  .last_of_image (out_o.last_of_image)
);
